/* design/phn_pkg.sv */
// shared types and constants for the pixel histogram block
package phn_pkg;

  localparam int PIX_W       = 8;
  localparam int FIELD_CNT_W = 23;
  localparam int HEIGHT_W    = 10;
  localparam int MAX_CH      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [HEIGHT_W-1:0]  HEIGHT_MAX      = '1;
  localparam logic [HEIGHT_W-1:0]  PLOT_HEIGHT_RST = 10'd400;
  localparam logic                 COLOUR_MODE_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_RD_RD,
    S_RD_MUL,
    S_RD_DIV,
    S_RD_WAIT,
    S_RD_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PIX_W-1:0] first_value;
    logic [PIX_W-1:0] second_value;
    logic [PIX_W-1:0] third_value;
    logic [PIX_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]       bin_number;
    logic [FIELD_CNT_W-1:0] count_first;
    logic [FIELD_CNT_W-1:0] count_second;
    logic [FIELD_CNT_W-1:0] count_third;
    logic [HEIGHT_W-1:0]    height_first;
    logic [HEIGHT_W-1:0]    height_second;
    logic [HEIGHT_W-1:0]    height_third;
    logic [FIELD_CNT_W-1:0] peak_count;
    logic                   empty_flag;
  } out_item_t;

  typedef struct packed {
    logic in_take;
    logic clr_peak;
    logic clr_en;
    logic mem_rd;
    logic cnt_wr;
    logic mul_en;
    logic div_start;
    logic out_load;
  } phn_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic clr_last;
    logic div_done;
    logic out_free;
  } phn_sts_t;

endpackage

/* design/pixel_histogram_normalized_core.sv */
// top level of the 256-bin pixel histogram with normalised bin readout
//
// Histogram of 8-bit pixels, one gray channel or up to three colour channels, with a running
// peak and readout scaled as round(count * plot_height / peak), ties to even. One beat is
// handled at a time. Counting a pixel is a read and a write-back of each channel's single-port
// bin memory. Clearing writes one bin address per cycle in all channel memories at once; the
// same clearing pass runs after reset, with in_stall high throughout. Reading a bin is paced
// by the bit-serial divider that scales each channel, whose numerator is NUM_W bits wide (the
// count width plus ten); the channel dividers run side by side. The result is held in an output
// register, so a finished result does not hold up later clear or count beats.
module pixel_histogram_normalized_core
  import phn_pkg::*;
#(
  parameter int BIN_COUNT  = 256,
  parameter int MAX_PIXELS = 4194304,
  parameter int CHANNELS   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  phn_cmd_t cmd;
  phn_sts_t sts;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  phn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  phn_dp #(
    .BIN_COUNT  (BIN_COUNT),
    .MAX_PIXELS (MAX_PIXELS),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* design/phn_div.sv */
// iterative restoring divider with round-half-to-even and height saturation
module phn_div
  import phn_pkg::*;
#(
  parameter int NUM_W = 33,
  parameter int DEN_W = 23
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [HEIGHT_W-1:0] quot
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

  logic                busy_r, busy_nxt;
  logic                fin_r, fin_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [HEIGHT_W-1:0] quot_r, quot_nxt;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      diff;
  logic                ge;
  logic [DEN_W:0]      twice_rem;
  logic                round_up;
  logic [NUM_W:0]      q_rnd;

  always_comb begin
    rem_sh    = {rem_r, num_r[NUM_W-1]};
    ge        = rem_sh >= {1'b0, den_r};
    diff      = rem_sh - {1'b0, den_r};
    twice_rem = {rem_r, 1'b0};
    round_up  = (twice_rem > {1'b0, den_r}) ||
                ((twice_rem == {1'b0, den_r}) && num_r[0]);
    q_rnd     = {1'b0, num_r} + (NUM_W+1)'(round_up);

    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_nxt  = {num_r[NUM_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      if (q_rnd > (NUM_W+1)'(HEIGHT_MAX)) begin
        quot_nxt = HEIGHT_MAX;
      end else begin
        quot_nxt = q_rnd[HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* design/phn_ctrl.sv */
// controller state machine sequencing clear, count and readout
module phn_ctrl
  import phn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  phn_sts_t sts,
  output phn_cmd_t cmd,
  output logic     in_stall
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          case (sts.in_op)
            OP_CLEAR: begin
              cmd.clr_peak = 1'b1;
              state_nxt    = S_CLEAR;
            end
            OP_COUNT: state_nxt = S_CNT_RD;
            OP_READ:  state_nxt = S_RD_RD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_RD_MUL;
      end
      S_RD_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RD_DIV;
      end
      S_RD_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

/* design/phn_dp.sv */
// datapath: bin memories, peak, configuration, scaling and result register
module phn_dp
  import phn_pkg::*;
#(
  parameter int BIN_COUNT  = 256,
  parameter int MAX_PIXELS = 4194304,
  parameter int CHANNELS   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phn_cmd_t              cmd,
  output phn_sts_t              sts,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int NUM_W = CNT_W + HEIGHT_W;
  localparam logic [PIX_W:0]     BIN_LIMIT = (PIX_W+1)'(BIN_COUNT);
  localparam logic [IDX_W-1:0]   BIN_LAST  = IDX_W'(BIN_COUNT - 1);
  localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(MAX_PIXELS);

  function automatic logic [IDX_W-1:0] clamp_bin(input logic [PIX_W-1:0] v);
    logic [IDX_W-1:0] res;
    if ({1'b0, v} >= BIN_LIMIT) begin
      res = BIN_LAST;
    end else begin
      res = IDX_W'(v);
    end
    return res;
  endfunction

  in_item_t             item_r;
  logic                 colour_mode_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic [CNT_W-1:0]     peak_r, peak_nxt;
  logic [IDX_W-1:0]     clr_addr_r;
  logic                 out_valid_r;
  out_item_t            out_data_r, out_data_nxt;

  logic [PIX_W-1:0]     pix      [MAX_CH];
  logic                 act      [MAX_CH];
  logic [CNT_W-1:0]     rd_val   [MAX_CH];
  logic [CNT_W-1:0]     inc_val  [MAX_CH];
  logic [HEIGHT_W-1:0]  hgt_val  [MAX_CH];
  logic                 done_val [MAX_CH];
  logic [IDX_W-1:0]     read_bin;
  logic                 empty;

  assign pix[0]   = item_r.first_value;
  assign pix[1]   = item_r.second_value;
  assign pix[2]   = item_r.third_value;
  assign read_bin = clamp_bin(item_r.bin_index);
  assign empty    = (peak_r == '0);

  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      logic [CNT_W-1:0] mem [BIN_COUNT];
      logic [CNT_W-1:0] rd_r;
      logic [NUM_W-1:0] prod_r;
      logic [IDX_W-1:0] cnt_bin;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [CNT_W-1:0] wr_data;

      assign act[c]     = (c == 0) || colour_mode_r;
      assign cnt_bin    = clamp_bin(pix[c]);
      assign rd_addr    = (op_t'(item_r.opcode) == OP_READ) ? read_bin : cnt_bin;
      assign wr_en      = cmd.clr_en || (cmd.cnt_wr && act[c]);
      assign wr_addr    = cmd.clr_en ? clr_addr_r : cnt_bin;
      assign inc_val[c] = (rd_r < CNT_LIMIT) ? rd_r + CNT_W'(1) : rd_r;
      assign wr_data    = cmd.clr_en ? '0 : inc_val[c];
      assign rd_val[c]  = rd_r;

      always_ff @(posedge clk) begin
        if (wr_en) begin
          mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
          rd_r <= mem[rd_addr];
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.mul_en) begin
          prod_r <= NUM_W'(rd_r) * NUM_W'(height_r);
        end
      end

      phn_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
      ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_r),
        .den   (peak_r),
        .done  (done_val[c]),
        .quot  (hgt_val[c])
      );
    end else begin : g_off
      assign act[c]      = 1'b0;
      assign rd_val[c]   = '0;
      assign inc_val[c]  = '0;
      assign hgt_val[c]  = '0;
      assign done_val[c] = 1'b0;
    end
  end

  // running peak over the active channels
  always_comb begin
    peak_nxt = peak_r;
    if (cmd.clr_peak) begin
      peak_nxt = '0;
    end else if (cmd.cnt_wr) begin
      for (int c = 0; c < MAX_CH; c++) begin
        if (act[c] && (inc_val[c] > peak_nxt)) begin
          peak_nxt = inc_val[c];
        end
      end
    end
  end

  always_comb begin
    out_data_nxt               = out_data_r;
    out_data_nxt.bin_number    = PIX_W'(read_bin);
    out_data_nxt.count_first   = act[0] ? FIELD_CNT_W'(rd_val[0]) : '0;
    out_data_nxt.count_second  = act[1] ? FIELD_CNT_W'(rd_val[1]) : '0;
    out_data_nxt.count_third   = act[2] ? FIELD_CNT_W'(rd_val[2]) : '0;
    out_data_nxt.height_first  = (act[0] && !empty) ? hgt_val[0] : '0;
    out_data_nxt.height_second = (act[1] && !empty) ? hgt_val[1] : '0;
    out_data_nxt.height_third  = (act[2] && !empty) ? hgt_val[2] : '0;
    out_data_nxt.peak_count    = FIELD_CNT_W'(peak_r);
    out_data_nxt.empty_flag    = empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_mode_r <= COLOUR_MODE_RST;
      height_r      <= PLOT_HEIGHT_RST;
      peak_r        <= '0;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOUR_MODE: colour_mode_r <= cfg_data[0];
          CFG_PLOT_HEIGHT: height_r      <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      peak_r <= peak_nxt;
      if (cmd.clr_en) begin
        clr_addr_r <= (clr_addr_r == BIN_LAST) ? '0 : clr_addr_r + IDX_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.in_op    = op_t'(in_data.opcode);
  assign sts.clr_last = (clr_addr_r == BIN_LAST);
  assign sts.div_done = done_val[0];
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
